// File: rtl/multichannel_waveform_sampler_assert.svh
// assertion macros shared by the sampler checker
`ifndef MULTICHANNEL_WAVEFORM_SAMPLER_ASSERT_SVH
`define MULTICHANNEL_WAVEFORM_SAMPLER_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define MWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mws_checker: property failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define MWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mws_checker: property failed");

`endif

// File: rtl/mws_pkg.sv
// shared types, codes and fixed-point constants of the waveform sampler
package mws_pkg;

    localparam int OP_W         = 33;
    localparam int PROD_W       = 66;
    localparam int WAVE_W       = 17;
    localparam int V_W          = 19;
    localparam int SAMPLE_MAX_W = 24;
    localparam int Q_FRAC       = 30;
    localparam int G_FRAC       = 15;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] GAIN_ONE  = 16'h8000;

    localparam longint unsigned DEFAULT_RATE_HZ = 64'd1000;

    localparam logic signed [OP_W-1:0] COEF_C1   = 33'sd1686629713;
    localparam logic signed [OP_W-1:0] COEF_C3   = -33'sd693598342;
    localparam logic signed [OP_W-1:0] COEF_C5   = 33'sd85568390;
    localparam logic signed [OP_W-1:0] COEF_C7   = -33'sd5026880;
    localparam logic signed [OP_W-1:0] COEF_C9   = 33'sd172271;
    localparam logic signed [OP_W-1:0] SINE_PEAK = 33'sd32767;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_READ  = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_OPEN  = 3'd3,
        ACT_CLOSE = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_ZERO     = 2'd3
    } wave_t;

    // rounded phase step of (ch + 1) * 0.5 Hz at the default sample rate
    function automatic logic [31:0] default_step(input int unsigned ch);
        logic [63:0] num;
        num = 64'(ch + 1) << 32;
        return 32'((num + DEFAULT_RATE_HZ) / (2 * DEFAULT_RATE_HZ));
    endfunction

    // horner coefficients after the leading c9 term
    function automatic logic signed [OP_W-1:0] horner_coef(input logic [1:0] step);
        logic signed [OP_W-1:0] c;
        case (step)
            2'd0:    c = COEF_C7;
            2'd1:    c = COEF_C5;
            2'd2:    c = COEF_C3;
            default: c = COEF_C1;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/multichannel_waveform_sampler.sv
// eight-channel sampled waveform generator with one shared multiplier
//
//   channel  | handshake          | word
//   ---------+--------------------+-------------------------------------------
//   input    | in_valid/in_stall  | action, channel, settings fields
//   output   | out_valid/out_stall| sample (one word per read)
//
// read, settings write, open and close are done without leaving the idle state
// a tick while open holds in_stall while it takes each channel in turn through the phase,
//   sine polynomial (sine only), gain, noise (noise on) and output states
// every product goes through the one 33 x 33 multiplier, one per cycle
// rst_n returns all settings to their defaults, clears samples and the tick counter and closes the device
// a read is held back while a tick is running or while the previous output word is stalled
module multichannel_waveform_sampler #(
    parameter int CHANNELS        = 8,
    parameter int SAMPLE_BITS     = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [2:0]         channel,
    input  logic [1:0]         waveform,
    input  logic [31:0]        phase_step,
    input  logic [15:0]        gain,
    input  logic signed [16:0] level_shift,
    input  logic [15:0]        noise_amount,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample
);

    localparam int OP_W    = mws_pkg::OP_W;
    localparam int PROD_W  = mws_pkg::PROD_W;
    localparam int WAVE_W  = mws_pkg::WAVE_W;
    localparam int V_W     = mws_pkg::V_W;
    localparam int SMW     = mws_pkg::SAMPLE_MAX_W;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QTR_LEN = 1 << SINE_TABLE_BITS;
    localparam int K_W     = SINE_TABLE_BITS + 1;
    localparam int X_SHIFT = mws_pkg::Q_FRAC - SINE_TABLE_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_PHASE,
        S_XSQ,
        S_HORNER,
        S_POLY_X,
        S_PEAK,
        S_GAIN,
        S_NOISE,
        S_OUT
    } state_t;

    state_t                   state_reg;
    logic                     open_reg;
    logic [31:0]              tick_reg;
    logic [CH_W-1:0]          ch_reg;
    logic [1:0]               hstep_reg;
    logic signed [OP_W-1:0]   opa_reg;
    logic signed [OP_W-1:0]   opb_reg;
    logic signed [OP_W-1:0]   x_reg;
    logic signed [OP_W-1:0]   x2_reg;
    logic                     neg_reg;
    logic signed [V_W-1:0]    v_reg;
    logic [15:0]              lfsr_reg;
    logic                     out_valid_reg;
    logic signed [15:0]       sample_reg;

    logic [1:0]               wave_reg   [CHANNELS];
    logic [31:0]              step_reg   [CHANNELS];
    logic [15:0]              gain_reg   [CHANNELS];
    logic signed [16:0]       shift_reg  [CHANNELS];
    logic [15:0]              noise_reg  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] latest_reg [CHANNELS];

    logic                     in_accept;
    logic                     ch_ok;
    logic [CH_W-1:0]          in_ch;
    logic signed [SAMPLE_BITS-1:0] rd_val;
    logic signed [SMW-1:0]    rd_ext;
    logic signed [15:0]       sample_next;

    logic signed [OP_W-1:0]   mul_a;
    logic signed [OP_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] sh30;
    logic signed [PROD_W-1:0] sh15;
    logic signed [PROD_W-1:0] peak_round;
    logic signed [PROD_W-1:0] out_round;

    logic [31:0]              phase;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [K_W-1:0]           k_val;
    logic signed [OP_W-1:0]   x_val;
    logic signed [17:0]       tri_d;
    logic signed [17:0]       tri_abs;
    logic signed [17:0]       tri_w;
    logic signed [WAVE_W-1:0] basic_w;
    logic [15:0]              peak_e;
    logic signed [WAVE_W-1:0] sine_w;
    logic signed [OP_W-1:0]   poly_next;
    logic signed [V_W-1:0]    v_gain;
    logic signed [V_W-1:0]    v_noise;
    logic [15:0]              lfsr_next;
    logic signed [17:0]       noise_op;
    logic signed [SAMPLE_BITS-1:0] sat_val;

    assign in_stall  = (state_reg != S_IDLE)
                     || (out_valid_reg && out_stall && (action == mws_pkg::ACT_READ));
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    assign ch_ok       = ({2'b00, channel} < 5'(CHANNELS));
    assign in_ch       = CH_W'(channel);
    assign rd_val      = (open_reg && ch_ok) ? latest_reg[in_ch] : '0;
    assign rd_ext      = SMW'(rd_val);
    assign sample_next = rd_ext[15:0];

    // shared multiplier, phase operands are the tick counter and the step from the settings row
    always_comb
    begin
        if (state_reg == S_PHASE)
        begin
            mul_a = $signed({1'b0, tick_reg});
            mul_b = $signed({1'b0, step_reg[ch_reg]});
        end
        else
        begin
            mul_a = opa_reg;
            mul_b = opb_reg;
        end
    end

    assign prod       = mul_a * mul_b;
    assign sh30       = prod >>> 30;
    assign sh15       = prod >>> 15;
    assign peak_round = (prod + 66'sd536870912) >>> 30;
    assign out_round  = (prod + 66'sd16384) >>> 15;

    // quadrant mirroring of the quarter wave
    assign phase = prod[31:0];
    assign idx   = phase[29 -: SINE_TABLE_BITS];
    assign k_val = phase[30] ? (K_W'(QTR_LEN) - {1'b0, idx}) : {1'b0, idx};
    assign x_val = $signed(OP_W'(k_val) << X_SHIFT);

    assign tri_d   = $signed({2'b00, phase[31:16]}) - 18'sd32768;
    assign tri_abs = tri_d[17] ? -tri_d : tri_d;
    assign tri_w   = (tri_abs <<< 1) - 18'sd32768;

    always_comb
    begin
        unique case (wave_reg[ch_reg])
            mws_pkg::WAVE_SQUARE:   basic_w = phase[31] ? -17'sd32768 : 17'sd32768;
            mws_pkg::WAVE_TRIANGLE: basic_w = WAVE_W'(tri_w);
            default:                basic_w = '0;
        endcase
    end

    always_comb
    begin
        if (peak_round < 0)
            peak_e = 16'd0;
        else if (peak_round > 66'sd32767)
            peak_e = 16'd32767;
        else
            peak_e = peak_round[15:0];
    end

    assign sine_w    = neg_reg ? -$signed({1'b0, peak_e}) : $signed({1'b0, peak_e});
    assign poly_next = mws_pkg::horner_coef(hstep_reg) + OP_W'(sh30);
    assign v_gain    = V_W'(sh15) + V_W'(shift_reg[ch_reg]);
    assign v_noise   = v_reg + V_W'(sh15);

    // galois step, taps 0xb400
    assign lfsr_next = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? mws_pkg::LFSR_TAPS : 16'h0000);
    assign noise_op  = $signed({2'b00, lfsr_next}) - 18'sd32768;

    always_comb
    begin
        if (out_round > PROD_W'(SMAX))
            sat_val = SMAX;
        else if (out_round < PROD_W'(SMIN))
            sat_val = SMIN;
        else
            sat_val = out_round[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            open_reg      <= 1'b0;
            tick_reg      <= '0;
            ch_reg        <= '0;
            hstep_reg     <= '0;
            opa_reg       <= '0;
            opb_reg       <= '0;
            x_reg         <= '0;
            x2_reg        <= '0;
            neg_reg       <= 1'b0;
            v_reg         <= '0;
            lfsr_reg      <= mws_pkg::LFSR_SEED;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wave_reg[i]   <= mws_pkg::WAVE_SINE;
                step_reg[i]   <= mws_pkg::default_step(i);
                gain_reg[i]   <= mws_pkg::GAIN_ONE;
                shift_reg[i]  <= '0;
                noise_reg[i]  <= '0;
                latest_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall && !(in_accept && (action == mws_pkg::ACT_READ)))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        unique case (action)
                            mws_pkg::ACT_TICK:
                            begin
                                if (open_reg)
                                begin
                                    ch_reg    <= '0;
                                    state_reg <= S_PHASE;
                                end
                            end
                            mws_pkg::ACT_READ:
                            begin
                                out_valid_reg <= 1'b1;
                                sample_reg    <= sample_next;
                            end
                            mws_pkg::ACT_WRITE:
                            begin
                                if (open_reg && ch_ok)
                                begin
                                    wave_reg[in_ch]  <= waveform;
                                    step_reg[in_ch]  <= phase_step;
                                    gain_reg[in_ch]  <= gain;
                                    shift_reg[in_ch] <= level_shift;
                                    noise_reg[in_ch] <= noise_amount;
                                end
                            end
                            mws_pkg::ACT_OPEN:
                            begin
                                open_reg <= 1'b1;
                                tick_reg <= '0;
                                lfsr_reg <= mws_pkg::LFSR_SEED;
                                for (int i = 0; i < CHANNELS; i++)
                                begin
                                    wave_reg[i]   <= mws_pkg::WAVE_SINE;
                                    step_reg[i]   <= mws_pkg::default_step(i);
                                    gain_reg[i]   <= mws_pkg::GAIN_ONE;
                                    shift_reg[i]  <= '0;
                                    noise_reg[i]  <= '0;
                                    latest_reg[i] <= '0;
                                end
                            end
                            mws_pkg::ACT_CLOSE:
                            begin
                                open_reg <= 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_PHASE:
                begin
                    if (wave_reg[ch_reg] == mws_pkg::WAVE_SINE)
                    begin
                        x_reg     <= x_val;
                        opa_reg   <= x_val;
                        opb_reg   <= x_val;
                        neg_reg   <= phase[31];
                        state_reg <= S_XSQ;
                    end
                    else
                    begin
                        opa_reg   <= OP_W'(basic_w);
                        opb_reg   <= $signed({17'b0, gain_reg[ch_reg]});
                        state_reg <= S_GAIN;
                    end
                end

                S_XSQ:
                begin
                    x2_reg    <= OP_W'(sh30);
                    opa_reg   <= mws_pkg::COEF_C9;
                    opb_reg   <= OP_W'(sh30);
                    hstep_reg <= '0;
                    state_reg <= S_HORNER;
                end

                S_HORNER:
                begin
                    opa_reg <= poly_next;
                    if (hstep_reg == 2'd3)
                    begin
                        opb_reg   <= x_reg;
                        state_reg <= S_POLY_X;
                    end
                    else
                    begin
                        opb_reg   <= x2_reg;
                        hstep_reg <= hstep_reg + 2'd1;
                    end
                end

                S_POLY_X:
                begin
                    opa_reg   <= OP_W'(sh30);
                    opb_reg   <= mws_pkg::SINE_PEAK;
                    state_reg <= S_PEAK;
                end

                S_PEAK:
                begin
                    opa_reg   <= OP_W'(sine_w);
                    opb_reg   <= $signed({17'b0, gain_reg[ch_reg]});
                    state_reg <= S_GAIN;
                end

                S_GAIN:
                begin
                    if (noise_reg[ch_reg] != 16'd0)
                    begin
                        v_reg     <= v_gain;
                        lfsr_reg  <= lfsr_next;
                        opa_reg   <= OP_W'(noise_op);
                        opb_reg   <= $signed({17'b0, noise_reg[ch_reg]});
                        state_reg <= S_NOISE;
                    end
                    else
                    begin
                        opa_reg   <= OP_W'(v_gain);
                        opb_reg   <= OP_W'(SMAX);
                        state_reg <= S_OUT;
                    end
                end

                S_NOISE:
                begin
                    opa_reg   <= OP_W'(v_noise);
                    opb_reg   <= OP_W'(SMAX);
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    latest_reg[ch_reg] <= sat_val;
                    if (ch_reg == CH_W'(CHANNELS - 1))
                    begin
                        tick_reg  <= tick_reg + 32'd1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= S_PHASE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/mws_checker.sv
// port-level checker for the waveform sampler and its bind
`include "multichannel_waveform_sampler_assert.svh"

module mws_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [2:0]         action,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] sample
);

    logic acc;
    logic acc_read;
    logic acc_oc;

    assign acc      = in_valid && !in_stall;
    assign acc_read = acc && (action == mws_pkg::ACT_READ);
    assign acc_oc   = acc && (action == mws_pkg::ACT_OPEN || action == mws_pkg::ACT_CLOSE);

    // stalled output word stays put
    `MWS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample))

    // every accepted read yields a word in the next cycle
    `MWS_ASSERT_NEXT(a_read_word, acc_read, out_valid)

    // a new word only follows an accepted read
    `MWS_ASSERT_NOW(a_word_cause, $rose(out_valid), $past(acc_read))

    // straight after open or close every read gives zero
    `MWS_ASSERT_NEXT(a_zero_after_oc, acc_oc ##1 acc_read, sample == 16'sd0)

endmodule

bind multichannel_waveform_sampler mws_checker u_mws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
);

// File: test/tb.sv
// testbench for the waveform sampler: directed table then random words against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH = 8;
    localparam int TBL_BITS = 10;
    localparam int QTR_LEN = 1 << TBL_BITS;
    localparam longint FULL_SCALE = 32767;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int RANDOM_WORDS = 1300;
    localparam int LONG_HOLD_AT = 400;
    localparam int LONG_HOLD = 400;
    localparam int SHOW_MAX = 10;

    typedef struct {
        logic [2:0]         act;
        logic [2:0]         ch;
        mws_pkg::wave_t     wave;
        logic [31:0]        step;
        logic [15:0]        gain;
        logic signed [16:0] shift;
        logic [15:0]        noise;
        bit                 typed;
        logic [15:0]        want;
    } word_t;

    typedef struct {
        mws_pkg::wave_t     wave;
        logic [31:0]        step;
        logic [15:0]        gain;
        logic signed [16:0] shift;
        logic [15:0]        noise;
    } chan_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         action = '0;
    logic [2:0]         channel = '0;
    logic [1:0]         waveform = '0;
    logic [31:0]        phase_step = '0;
    logic [15:0]        gain = '0;
    logic signed [16:0] level_shift = '0;
    logic [15:0]        noise_amount = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] sample;

    longint      sine_qtr [0:QTR_LEN];
    logic [31:0] ticks_done;
    bit          is_open;
    logic [15:0] held [NCH];
    chan_row_t   rows [NCH];
    logic [15:0] lfsr;

    logic [15:0] sample_due [$];
    int mismatches = 0;
    int strays = 0;
    int leftovers = 0;
    int shown = 0;
    int words_sent = 0;
    int ticks_seen = 0;
    int writes_seen = 0;
    int reads_checked = 0;
    bit long_hold_done = 1'b0;

    multichannel_waveform_sampler DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .channel      (channel),
        .waveform     (waveform),
        .phase_step   (phase_step),
        .gain         (gain),
        .level_shift  (level_shift),
        .noise_amount (noise_amount),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // quarter-wave sine by odd polynomial in Q30
    function automatic void build_sine();
        longint x, x2, p, s, e;
        int k;
        for (k = 0; k <= QTR_LEN; k++)
        begin
            x  = longint'(k) << (30 - TBL_BITS);
            x2 = (x * x) >>> 30;
            p  = longint'(mws_pkg::COEF_C9);
            p  = longint'(mws_pkg::COEF_C7) + ((p * x2) >>> 30);
            p  = longint'(mws_pkg::COEF_C5) + ((p * x2) >>> 30);
            p  = longint'(mws_pkg::COEF_C3) + ((p * x2) >>> 30);
            p  = longint'(mws_pkg::COEF_C1) + ((p * x2) >>> 30);
            s  = (p * x) >>> 30;
            e  = (s * longint'(mws_pkg::SINE_PEAK) + (longint'(1) << 29)) >>> 30;
            if (e < 0)
                e = 0;
            if (e > 32767)
                e = 32767;
            sine_qtr[k] = e;
        end
    endfunction

    function automatic void clear_rows();
        int i;
        ticks_done = '0;
        lfsr = mws_pkg::LFSR_SEED;
        for (i = 0; i < NCH; i++)
        begin
            held[i] = '0;
            rows[i].wave = mws_pkg::WAVE_SINE;
            rows[i].step = 32'(((64'(i + 1) << 32) + mws_pkg::DEFAULT_RATE_HZ)
                               / (2 * mws_pkg::DEFAULT_RATE_HZ));
            rows[i].gain = mws_pkg::GAIN_ONE;
            rows[i].shift = '0;
            rows[i].noise = '0;
        end
    endfunction

    function automatic longint wave_level(input mws_pkg::wave_t w, input logic [31:0] ph);
        int idx;
        longint t;
        case (w)
            mws_pkg::WAVE_SINE:
            begin
                idx = int'((ph >> (30 - TBL_BITS)) & (QTR_LEN - 1));
                t = ph[30] ? sine_qtr[QTR_LEN - idx] : sine_qtr[idx];
                return ph[31] ? -t : t;
            end
            mws_pkg::WAVE_SQUARE:
                return ph[31] ? -32768 : 32768;
            mws_pkg::WAVE_TRIANGLE:
            begin
                t = longint'(ph[31:16]) - 32768;
                if (t < 0)
                    t = -t;
                return 2 * t - 32768;
            end
            default:
                return 0;
        endcase
    endfunction

    function automatic logic [15:0] channel_sample(input int c, input logic [31:0] ph);
        longint v, o;
        logic lsb;
        v = ((wave_level(rows[c].wave, ph) * longint'(rows[c].gain)) >>> 15)
            + longint'(rows[c].shift);
        if (rows[c].noise != 0)
        begin
            lsb = lfsr[0];
            lfsr = lfsr >> 1;
            if (lsb)
                lfsr = lfsr ^ mws_pkg::LFSR_TAPS;
            v += ((longint'(lfsr) - 32768) * longint'(rows[c].noise)) >>> 15;
        end
        o = (v * FULL_SCALE + 16384) >>> 15;
        if (o > FULL_SCALE)
            o = FULL_SCALE;
        if (o < -FULL_SCALE - 1)
            o = -FULL_SCALE - 1;
        return 16'(o);
    endfunction

    // applies one word to the predicted state, returns 1 when a sample word is due
    function automatic bit advance_sampler(input word_t w, output logic [15:0] s);
        int i;
        bit has_out;
        has_out = 1'b0;
        s = '0;
        case (w.act)
            mws_pkg::ACT_TICK:
                if (is_open)
                begin
                    for (i = 0; i < NCH; i++)
                        held[i] = channel_sample(i, 32'(ticks_done * rows[i].step));
                    ticks_done = ticks_done + 1;
                    ticks_seen++;
                end
            mws_pkg::ACT_READ:
            begin
                has_out = 1'b1;
                if (is_open)
                    s = held[w.ch];
            end
            mws_pkg::ACT_WRITE:
                if (is_open)
                begin
                    rows[w.ch].wave = w.wave;
                    rows[w.ch].step = w.step;
                    rows[w.ch].gain = w.gain;
                    rows[w.ch].shift = w.shift;
                    rows[w.ch].noise = w.noise;
                    writes_seen++;
                end
            mws_pkg::ACT_OPEN:
            begin
                clear_rows();
                is_open = 1'b1;
            end
            mws_pkg::ACT_CLOSE:
                is_open = 1'b0;
            default:
                ;
        endcase
        return has_out;
    endfunction

    function automatic int gap_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic word_t row(input logic [2:0] act, input logic [2:0] ch,
                                  input mws_pkg::wave_t wave,
                                  input logic [31:0] step, input logic [15:0] gn,
                                  input logic [16:0] shift, input logic [15:0] noise,
                                  input bit typed = 1'b0, input logic [15:0] want = '0);
        word_t w;
        w.act = act;
        w.ch = ch;
        w.wave = wave;
        w.step = step;
        w.gain = gn;
        w.shift = shift;
        w.noise = noise;
        w.typed = typed;
        w.want = want;
        return w;
    endfunction

    function automatic word_t random_word();
        word_t w;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            w.act = mws_pkg::ACT_TICK;
        else if (r < 63)
            w.act = mws_pkg::ACT_READ;
        else if (r < 91)
            w.act = mws_pkg::ACT_WRITE;
        else if (r < 94)
            w.act = mws_pkg::ACT_OPEN;
        else if (r < 96)
            w.act = mws_pkg::ACT_CLOSE;
        else
            w.act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        w.ch = 3'($urandom_range(0, NCH - 1));
        w.wave = mws_pkg::wave_t'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 15)
            w.step = 32'($urandom_range(0, 65535));
        else if (r < 22)
            w.step = '0;
        else if (r < 28)
            w.step = '1;
        else
            w.step = $urandom;
        r = $urandom_range(0, 99);
        if (r < 10)
            w.gain = '0;
        else if (r < 20)
            w.gain = '1;
        else if (r < 40)
            w.gain = mws_pkg::GAIN_ONE;
        else
            w.gain = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8)
            w.shift = 17'h10000;
        else if (r < 16)
            w.shift = 17'h0FFFF;
        else if (r < 50)
            w.shift = '0;
        else
            w.shift = 17'($urandom);
        r = $urandom_range(0, 99);
        if (r < 50)
            w.noise = '0;
        else if (r < 58)
            w.noise = '1;
        else
            w.noise = 16'($urandom);
        w.typed = 1'b0;
        w.want = '0;
        return w;
    endfunction

    task automatic send_word(input word_t w, input bit calm);
        int gap;
        logic [15:0] s;
        gap = gap_len(calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= w.act;
        channel <= w.ch;
        waveform <= w.wave;
        phase_step <= w.step;
        gain <= w.gain;
        level_shift <= w.shift;
        noise_amount <= w.noise;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (advance_sampler(w, s))
            sample_due.push_back(w.typed ? w.want : s);
    endtask

    initial
    begin : result_side
        int stall_left;
        int cyc;
        logic [15:0] due;
        stall_left = 0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (out_valid && !out_stall)
            begin
                if (sample_due.size() == 0)
                begin
                    strays++;
                    if (shown < SHOW_MAX)
                        $display("unexpected sample word %0d at %0t", sample, $realtime);
                    shown++;
                end
                else
                begin
                    due = sample_due.pop_front();
                    reads_checked++;
                    if (sample !== due)
                    begin
                        mismatches++;
                        if (shown < SHOW_MAX)
                            $display("sample mismatch at %0t: expected %0d, got %0d",
                                     $realtime, $signed(due), sample);
                        shown++;
                    end
                end
            end
            // one long hold-off so that a read backs up and the input stalls
            if (!long_hold_done && words_sent >= LONG_HOLD_AT)
            begin
                stall_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else if (stall_left == 0)
                stall_left = gap_len((cyc / 2000) % 4 == 1);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        word_t plan [$];
        word_t w;
        int counted;
        int waited;
        build_sine();
        clear_rows();
        is_open = 1'b0;
        plan = '{
            row(mws_pkg::ACT_READ,  3'd0, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000, 1'b1, 16'h0000),
            row(mws_pkg::ACT_TICK,  3'd0, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_WRITE, 3'd2, mws_pkg::WAVE_SQUARE,
                32'd5,        16'hFFFF, 17'h0FFFF, 16'h0000),
            row(ACT_SPARE_LO,       3'd1, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(ACT_SPARE_HI,       3'd6, mws_pkg::WAVE_ZERO,
                32'hFFFFFFFF, 16'hFFFF, 17'h1FFFF, 16'hFFFF),
            row(mws_pkg::ACT_OPEN,  3'd0, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_READ,  3'd7, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000, 1'b1, 16'h0000),
            row(mws_pkg::ACT_TICK,  3'd0, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_READ,  3'd3, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000, 1'b1, 16'h0000),
            row(mws_pkg::ACT_WRITE, 3'd2, mws_pkg::WAVE_SQUARE,
                32'd0,        16'hFFFF, 17'h0FFFF, 16'h0000),
            row(mws_pkg::ACT_WRITE, 3'd5, mws_pkg::WAVE_ZERO,
                32'hFFFFFFFF, 16'h0000, 17'h10000, 16'h0000),
            row(mws_pkg::ACT_WRITE, 3'd1, mws_pkg::WAVE_TRIANGLE,
                32'hFFFFFFFF, 16'h8000, 17'h00000, 16'hFFFF),
            row(mws_pkg::ACT_WRITE, 3'd6, mws_pkg::WAVE_SINE,
                32'h40000000, 16'hFFFF, 17'h00000, 16'h0001),
            row(mws_pkg::ACT_TICK,  3'd0, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_READ,  3'd2, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000, 1'b1, 16'h7FFF),
            row(mws_pkg::ACT_READ,  3'd5, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000, 1'b1, 16'h8000),
            row(mws_pkg::ACT_READ,  3'd1, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_READ,  3'd6, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_READ,  3'd0, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_CLOSE, 3'd0, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_READ,  3'd1, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000, 1'b1, 16'h0000),
            row(mws_pkg::ACT_TICK,  3'd0, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_WRITE, 3'd1, mws_pkg::WAVE_SQUARE,
                32'd0,        16'hFFFF, 17'h0FFFF, 16'h0000),
            row(mws_pkg::ACT_OPEN,  3'd0, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_OPEN,  3'd0, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000),
            row(mws_pkg::ACT_READ,  3'd2, mws_pkg::WAVE_SINE,
                32'd0,        16'h0000, 17'h00000, 16'h0000, 1'b1, 16'h0000)
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (plan[i])
            send_word(plan[i], 1'b0);
        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            w = random_word();
            counted++;
            send_word(w, (counted / 64) % 5 == 2);
        end
        in_valid <= 1'b0;
        waited = 0;
        while (sample_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (120) @(posedge clk);
        leftovers = sample_due.size();
        $display("covered %0d words: %0d ticks, %0d settings writes, %0d samples read back",
                 words_sent, ticks_seen, writes_seen, reads_checked);
        $display("%0d mismatches, %0d unexpected samples, %0d samples never returned",
                 mismatches, strays, leftovers);
        if (mismatches + strays + leftovers == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
